>>> rtl/acqa_pkg.sv
`timescale 1ns / 1ps
package acqa_pkg;

	localparam int DEF_SAMPLES     = 32;
	localparam int DEF_QUEUE_DEPTH = 32;
	localparam int DEF_CHANNELS    = 15;

	localparam int CH_W  = 4;
	localparam int SMP_W = 12;

	localparam logic [CH_W-1:0] NO_CHANNEL = 4'd15;

	localparam logic [1:0] CMD_ENQ    = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_SAMPLE = 2'd2;

	// Queue status seen by the sequencer.
	typedef struct packed {
		logic full;
		logic nonempty;
		logic multi;
	} qstat_t;

endpackage

>>> rtl/acqa_queue.sv
`timescale 1ns / 1ps
module acqa_queue import acqa_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [CH_W-1:0] push_data,
	input  logic            pop,
	output logic [CH_W-1:0] rd_data,
	output qstat_t          qstat
);

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int OW  = $clog2(QUEUE_DEPTH + 1);

	logic [CH_W-1:0] mem [QUEUE_DEPTH];
	logic [QAW-1:0]  head_q;
	logic [QAW-1:0]  tail_q;
	logic [OW-1:0]   occ_q;
	logic [QAW-1:0]  head_nxt;
	logic [QAW-1:0]  tail_nxt;

	assign head_nxt = (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
		end else if (push) begin
			tail_q <= tail_nxt;
			occ_q  <= occ_q + 1'b1;
		end else if (pop) begin
			head_q <= head_nxt;
			occ_q  <= occ_q - 1'b1;
		end
	end

	// A pop fetches the entry that becomes the new head.
	always_ff @(posedge clk) begin
		if (push)
			mem[tail_q] <= push_data;
		if (pop)
			rd_data <= mem[head_nxt];
	end

	assign qstat.full     = (occ_q == OW'(QUEUE_DEPTH));
	assign qstat.nonempty = (occ_q != '0);
	assign qstat.multi    = (occ_q > OW'(1));

endmodule

>>> rtl/acqa_sums.sv
`timescale 1ns / 1ps
module acqa_sums import acqa_pkg::*; #(
	parameter int CHANNELS  = DEF_CHANNELS,
	parameter int SUM_W     = SMP_W + $clog2(DEF_SAMPLES),
	localparam int CW_OUT   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [CW_OUT-1:0]         wr_idx,
	input  logic [SUM_W-1:0]          wr_data,
	input  logic                      rd_en,
	input  logic [CW_OUT-1:0]         rd_idx,
	input  logic                      clr_fresh,
	output logic                      fresh,
	output logic [SUM_W-1:0]          rd_data
);

	logic [SUM_W-1:0]    mem [CHANNELS];
	logic [CHANNELS-1:0] written_q;
	logic [CHANNELS-1:0] fresh_q;
	logic [SUM_W-1:0]    mem_rd_q;
	logic                rd_written_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			fresh_q      <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_idx] <= 1'b1;
				fresh_q[wr_idx]   <= 1'b1;
			end
			if (clr_fresh)
				fresh_q[rd_idx] <= 1'b0;
			if (rd_en)
				rd_written_q <= written_q[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_idx] <= wr_data;
		if (rd_en)
			mem_rd_q <= mem[rd_idx];
	end

	// An entry never written since reset reads as zero.
	assign rd_data = rd_written_q ? mem_rd_q : '0;
	assign fresh   = fresh_q[rd_idx];

endmodule

>>> rtl/acqa_div.sv
`timescale 1ns / 1ps
module acqa_div import acqa_pkg::*; #(
	parameter int SAMPLES = DEF_SAMPLES,
	parameter int SUM_W   = SMP_W + $clog2(DEF_SAMPLES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	output logic             done,
	output logic [SMP_W-1:0] quotient
);

	// Division by the constant SAMPLES as a multiply by its rounded-up reciprocal.
	// With SHIFT = SUM_W + ceil(log2(SAMPLES)) the quotient is exact for every
	// SUM_W-bit dividend.
	localparam int SHIFT  = SUM_W + $clog2(SAMPLES);
	localparam int RCP_W  = SUM_W + 2;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam longint unsigned RCP =
		((64'd1 << SHIFT) + 64'(SAMPLES - 1)) / 64'(SAMPLES);

	logic [RCP_W-1:0]  rcp;
	logic [PROD_W-1:0] prod;
	logic              done_q;
	logic [SMP_W-1:0]  quot_q;

	assign rcp  = RCP_W'(RCP);
	assign prod = PROD_W'(dividend) * PROD_W'(rcp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= start;
	end

	always_ff @(posedge clk) begin
		if (start)
			quot_q <= prod[SHIFT +: SMP_W];
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

>>> rtl/adc_channel_queue_averager.sv
`timescale 1ns / 1ps
// Enqueue, sample and ignored items give their result in the cycle after acceptance;
// a sample that ends a block with more channels queued goes via S_HEAD (queue memory read).
// A read of a valid channel goes via S_FETCH (sum memory read) and S_DIV (registered multiply).
// Otherwise one item per cycle while busy is low; busy is high in S_HEAD, S_FETCH and S_DIV.
// Results are strobed by done for one cycle; the receiver cannot stall them.
// Reset (arst_n, asynchronous) empties the queue, stops conversion and clears sums and flags.
module adc_channel_queue_averager import acqa_pkg::*; #(
	parameter int SAMPLES     = DEF_SAMPLES,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int CHANNELS    = DEF_CHANNELS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       cmd,
	input  logic [CH_W-1:0]  channel,
	input  logic [SMP_W-1:0] sample,
	output logic             done,
	output logic [SMP_W-1:0] read_value,
	output logic             start_valid,
	output logic [CH_W-1:0]  start_channel,
	output logic             enqueue_dropped,
	output logic             busy_res
);

	localparam int SUM_W = SMP_W + $clog2(SAMPLES);
	localparam int CNT_W = $clog2(SAMPLES);
	localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_HEAD  = 2'd1;
	localparam logic [1:0] S_FETCH = 2'd2;
	localparam logic [1:0] S_DIV   = 2'd3;

	logic [1:0]       state_q;
	logic             conv_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CH_W-1:0]  head_ch_q;

	logic             done_q;
	logic [SMP_W-1:0] read_value_q;
	logic             start_valid_q;
	logic [CH_W-1:0]  start_channel_q;
	logic             dropped_q;
	logic             busy_res_q;

	logic             accept;
	logic             ch_ok;
	logic             head_ok;
	logic             is_read;
	logic             fresh;
	logic             enq_req;
	logic             push;
	logic             kick;
	logic             complete;
	logic             pop;
	logic             conv_next;
	logic [SUM_W-1:0] sum_add;
	logic [CH_W-1:0]  q_rd_data;
	qstat_t           qstat;
	logic [SUM_W-1:0] sum_rd_data;
	logic             div_start;
	logic             div_done;
	logic [SMP_W-1:0] quotient;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign ch_ok   = (channel != NO_CHANNEL) && (32'(channel) < CHANNELS);
	assign head_ok = (32'(head_ch_q) < CHANNELS);
	assign is_read = accept && (cmd == CMD_READ) && ch_ok;

	// A read of a channel with fresh data puts that channel back in the queue.
	assign enq_req = accept && ch_ok && ((cmd == CMD_ENQ) || ((cmd == CMD_READ) && fresh));
	assign push    = enq_req && !qstat.full;
	assign kick    = push && !conv_q;

	assign sum_add  = sum_q + SUM_W'(sample);
	assign complete = accept && (cmd == CMD_SAMPLE) && conv_q && (cnt_q == CNT_W'(SAMPLES - 1));
	assign pop      = complete && qstat.nonempty;

	always_comb begin
		conv_next = conv_q;
		if (kick)
			conv_next = 1'b1;
		else if (complete && !qstat.multi)
			conv_next = 1'b0;
	end

	assign div_start = (state_q == S_FETCH);

	acqa_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(channel),
		.pop      (pop),
		.rd_data  (q_rd_data),
		.qstat    (qstat)
	);

	acqa_sums #(
		.CHANNELS(CHANNELS),
		.SUM_W   (SUM_W)
	) u_sums (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (complete && head_ok),
		.wr_idx   (CW'(head_ch_q)),
		.wr_data  (sum_add),
		.rd_en    (is_read),
		.rd_idx   (CW'(channel)),
		.clr_fresh(is_read && fresh),
		.fresh    (fresh),
		.rd_data  (sum_rd_data)
	);

	acqa_div #(
		.SAMPLES(SAMPLES),
		.SUM_W  (SUM_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_rd_data),
		.done    (div_done),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			conv_q          <= 1'b0;
			sum_q           <= '0;
			cnt_q           <= '0;
			head_ch_q       <= '0;
			done_q          <= 1'b0;
			read_value_q    <= '0;
			start_valid_q   <= 1'b0;
			start_channel_q <= '0;
			dropped_q       <= 1'b0;
			busy_res_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						conv_q          <= conv_next;
						read_value_q    <= '0;
						start_valid_q   <= kick;
						start_channel_q <= kick ? channel : '0;
						dropped_q       <= enq_req && qstat.full;
						busy_res_q      <= conv_next;
						if (kick) begin
							head_ch_q <= channel;
							sum_q     <= '0;
							cnt_q     <= '0;
						end else if ((cmd == CMD_SAMPLE) && conv_q) begin
							if (complete) begin
								sum_q <= '0;
								cnt_q <= '0;
							end else begin
								sum_q <= sum_add;
								cnt_q <= cnt_q + 1'b1;
							end
						end
						if (complete && qstat.multi)
							state_q <= S_HEAD;
						else if (is_read)
							state_q <= S_FETCH;
						else
							done_q <= 1'b1;
					end
				end
				S_HEAD: begin
					head_ch_q       <= q_rd_data;
					start_valid_q   <= 1'b1;
					start_channel_q <= q_rd_data;
					done_q          <= 1'b1;
					state_q         <= S_IDLE;
				end
				S_FETCH: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						read_value_q <= quotient;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done            = done_q;
	assign read_value      = read_value_q;
	assign start_valid     = start_valid_q;
	assign start_channel   = start_channel_q;
	assign enqueue_dropped = dropped_q;
	assign busy_res        = busy_res_q;

	// Every accepted item either reports at once or keeps the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done || busy))
		else $error("accepted item neither reported nor in progress");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while block still busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && start_valid) |-> busy_res)
		else $error("conversion started but busy_res low");

	a_conv_queue: assert property (@(posedge clk) disable iff (!arst_n)
		conv_q |-> qstat.nonempty)
		else $error("converting with an empty queue");

endmodule
